// ----- rtl/core/rba_pkg.sv -----
// ----------------------------------------------------------------------------
// Rectangle block allocator package
// Shared constants, operation codes and the controller/datapath interface
// structs.
// ----------------------------------------------------------------------------
package rba_pkg;

   localparam int NUM_PAGES_DEF = 16;
   localparam int PAGE_COLS_DEF = 32;
   localparam int PAGE_ROWS_DEF = 32;

   // Operation codes carried on the request op field.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;
      logic scan_start;
      logic scan_en;
      logic mod_start;
      logic mod_en;
      logic load_rsp;
   } rba_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_free;
      logic size_bad;
      logic range_bad;
      logic free_noop;
      logic hit;
      logic scan_fail;
      logic mod_done;
   } rba_stat_type;

endpackage

// ----- rtl/core/rba_datapath.sv -----
// ----------------------------------------------------------------------------
// Rectangle block allocator datapath
// Occupancy memory, clearing sweep, first-fit row scan with per-column free
// run counters, read-modify-write marking and the result register.
// ----------------------------------------------------------------------------
module rba_datapath import rba_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   parameter int PAGE_COLS = PAGE_COLS_DEF,
   parameter int PAGE_ROWS = PAGE_ROWS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_load,
   input  logic         req_op,
   input  logic [5:0]   req_rect_width,
   input  logic [5:0]   req_rect_height,
   input  logic [3:0]   req_page_index,
   input  logic [4:0]   req_corner_x,
   input  logic [4:0]   req_corner_y,
   input  rba_cmd_type  cmd,
   output rba_stat_type stat,
   output logic         rsp_found,
   output logic [3:0]   rsp_out_page,
   output logic [4:0]   rsp_out_x,
   output logic [4:0]   rsp_out_y,
   output logic         rsp_range_error
);

   localparam int DEPTH = NUM_PAGES * PAGE_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int RW    = $clog2(PAGE_ROWS);
   localparam int CW    = $clog2(PAGE_COLS);
   localparam int NW    = $clog2(PAGE_ROWS + 1);
   localparam int EW    = 8;

   localparam logic [AW-1:0] ROWS_A    = AW'(PAGE_ROWS);
   localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
   localparam logic [RW-1:0] ROW_LAST  = RW'(PAGE_ROWS - 1);
   localparam logic [PW-1:0] PAGE_LAST = PW'(NUM_PAGES - 1);

   // Latched request.
   logic       op_ff;
   logic [5:0] w_ff, h_ff;
   logic [3:0] pg_ff;
   logic [4:0] cx_ff, cy_ff;

   // Occupancy memory.
   logic [PAGE_COLS-1:0] occ_mem [DEPTH];
   logic [PAGE_COLS-1:0] rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;

   // Clearing sweep.
   logic [AW-1:0] clr_ff, clr_in;

   // Scan issue and read tags.
   logic [PW-1:0] sp_ff, sp_in;
   logic [RW-1:0] sr_ff, sr_in;
   logic          sdone_ff, sdone_in;
   logic          dv_ff, dv_in;
   logic [PW-1:0] dp_ff;
   logic [RW-1:0] dr_ff;
   logic          scan_issue;
   logic [AW-1:0] scan_addr;

   // Column free runs.
   logic [NW-1:0]        run_ff [PAGE_COLS];
   logic [NW-1:0]        new_run [PAGE_COLS];
   logic [PAGE_COLS-1:0] free_col;
   logic [PAGE_COLS-1:0] fits;
   logic                 eval, cand, hit;
   logic [CW-1:0]        hit_x;

   // Allocation result.
   logic          res_found_ff;
   logic [PW-1:0] res_page_ff;
   logic [CW-1:0] res_x_ff;
   logic [RW-1:0] res_y_ff;

   // Read-modify-write of a rectangle.
   logic [5:0]           mcnt_ff, mcnt_in;
   logic                 mdv_ff, mdv_in;
   logic [AW-1:0]        maddr_ff;
   logic                 mod_issue;
   logic [PW-1:0]        mpage;
   logic [RW-1:0]        mrow0;
   logic [CW:0]          mx;
   logic [AW-1:0]        mod_addr;
   logic [PAGE_COLS-1:0] mask;

   // Result register.
   logic       rsp_found_ff, rsp_range_error_ff;
   logic [3:0] rsp_page_ff;
   logic [4:0] rsp_x_ff, rsp_y_ff;

   // Request decode.
   logic size_bad, range_bad;

   assign size_bad  = (w_ff == '0) || (h_ff == '0) ||
                      (EW'(w_ff) > EW'(PAGE_COLS)) || (EW'(h_ff) > EW'(PAGE_ROWS));
   assign range_bad = (EW'(pg_ff) >= EW'(NUM_PAGES)) ||
                      (EW'(cx_ff) + EW'(w_ff) > EW'(PAGE_COLS)) ||
                      (EW'(cy_ff) + EW'(h_ff) > EW'(PAGE_ROWS));

   // Scan addressing.
   assign scan_issue = cmd.scan_en && !sdone_ff;
   assign scan_addr  = AW'(AW'(sp_ff) * ROWS_A + AW'(sr_ff));

   always_comb begin
      sp_in    = sp_ff;
      sr_in    = sr_ff;
      sdone_in = sdone_ff;
      dv_in    = scan_issue;
      if (cmd.scan_start) begin
         sp_in    = '0;
         sr_in    = '0;
         sdone_in = 1'b0;
         dv_in    = 1'b0;
      end else if (scan_issue) begin
         if (sr_ff == ROW_LAST) begin
            sr_in = '0;
            if (sp_ff == PAGE_LAST) begin
               sdone_in = 1'b1;
            end else begin
               sp_in = sp_ff + PW'(1);
            end
         end else begin
            sr_in = sr_ff + RW'(1);
         end
      end
   end

   // Row evaluation: a column is free over the window if its run of free
   // rows ending at the current row reaches the requested height.
   assign eval = cmd.scan_en && dv_ff;
   assign cand = (EW'(dr_ff) + EW'(1)) >= EW'(h_ff);

   always_comb begin
      for (int c = 0; c < PAGE_COLS; c++) begin
         if (rd_data_ff[c]) begin
            new_run[c] = '0;
         end else if (dr_ff == '0) begin
            new_run[c] = NW'(1);
         end else begin
            new_run[c] = run_ff[c] + NW'(1);
         end
         free_col[c] = EW'(new_run[c]) >= EW'(h_ff);
      end
   end

   always_comb begin
      for (int x = 0; x < PAGE_COLS; x++) begin
         fits[x] = (EW'(x) + EW'(w_ff)) <= EW'(PAGE_COLS);
         for (int c = 0; c < PAGE_COLS; c++) begin
            if (EW'(c) >= EW'(x) && EW'(c) < EW'(x) + EW'(w_ff) && !free_col[c]) begin
               fits[x] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hit_x = '0;
      for (int x = PAGE_COLS - 1; x >= 0; x--) begin
         if (fits[x]) begin
            hit_x = CW'(x);
         end
      end
   end

   assign hit = eval && cand && (|fits);

   // Rectangle modify addressing.
   assign mpage     = (op_ff == OP_ALLOC) ? res_page_ff : PW'(pg_ff);
   assign mrow0     = (op_ff == OP_ALLOC) ? res_y_ff : RW'(cy_ff);
   assign mx        = (op_ff == OP_ALLOC) ? (CW+1)'(res_x_ff) : (CW+1)'(cx_ff);
   assign mod_issue = cmd.mod_en && (mcnt_ff != h_ff);
   assign mod_addr  = AW'(AW'(mpage) * ROWS_A + AW'(mrow0) + AW'(mcnt_ff));

   always_comb begin
      for (int c = 0; c < PAGE_COLS; c++) begin
         mask[c] = (EW'(c) >= EW'(mx)) && (EW'(c) < EW'(mx) + EW'(w_ff));
      end
   end

   always_comb begin
      mcnt_in = mcnt_ff;
      mdv_in  = mod_issue;
      if (cmd.mod_start) begin
         mcnt_in = '0;
         mdv_in  = 1'b0;
      end else if (mod_issue) begin
         mcnt_in = mcnt_ff + 6'd1;
      end
   end

   assign clr_in  = cmd.clear_en ? clr_ff + AW'(1) : clr_ff;
   assign rd_en   = scan_issue || mod_issue;
   assign rd_addr = scan_issue ? scan_addr : mod_addr;

   // Memory: one read and one write port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= occ_mem[rd_addr];
      end
      if (cmd.clear_en) begin
         occ_mem[clr_ff] <= '0;
      end else if (mdv_ff) begin
         if (op_ff == OP_ALLOC) begin
            occ_mem[maddr_ff] <= rd_data_ff | mask;
         end else begin
            occ_mem[maddr_ff] <= rd_data_ff & ~mask;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         sp_ff    <= '0;
         sr_ff    <= '0;
         sdone_ff <= 1'b1;
         dv_ff    <= 1'b0;
         mcnt_ff  <= '0;
         mdv_ff   <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
         sr_ff    <= sr_in;
         sdone_ff <= sdone_in;
         dv_ff    <= dv_in;
         mcnt_ff  <= mcnt_in;
         mdv_ff   <= mdv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_load) begin
         op_ff        <= req_op;
         w_ff         <= req_rect_width;
         h_ff         <= req_rect_height;
         pg_ff        <= req_page_index;
         cx_ff        <= req_corner_x;
         cy_ff        <= req_corner_y;
         res_found_ff <= 1'b0;
      end else if (hit) begin
         res_found_ff <= 1'b1;
      end
      if (scan_issue) begin
         dp_ff <= sp_ff;
         dr_ff <= sr_ff;
      end
      if (mod_issue) begin
         maddr_ff <= mod_addr;
      end
      if (eval) begin
         for (int c = 0; c < PAGE_COLS; c++) begin
            run_ff[c] <= new_run[c];
         end
      end
      if (hit) begin
         res_page_ff <= dp_ff;
         res_x_ff    <= hit_x;
         res_y_ff    <= RW'(EW'(dr_ff) + EW'(1) - EW'(h_ff));
      end
      if (cmd.load_rsp) begin
         if (op_ff == OP_ALLOC) begin
            rsp_found_ff       <= res_found_ff;
            rsp_range_error_ff <= 1'b0;
            rsp_page_ff        <= res_found_ff ? 4'(res_page_ff) : 4'd0;
            rsp_x_ff           <= res_found_ff ? 5'(res_x_ff) : 5'd0;
            rsp_y_ff           <= res_found_ff ? 5'(res_y_ff) : 5'd0;
         end else begin
            rsp_found_ff       <= !range_bad;
            rsp_range_error_ff <= range_bad;
            rsp_page_ff        <= 4'd0;
            rsp_x_ff           <= 5'd0;
            rsp_y_ff           <= 5'd0;
         end
      end
   end

   assign stat.clear_last = (clr_ff == CLR_LAST);
   assign stat.is_free    = (op_ff == OP_FREE);
   assign stat.size_bad   = size_bad;
   assign stat.range_bad  = range_bad;
   assign stat.free_noop  = (w_ff == '0) || (h_ff == '0);
   assign stat.hit        = hit;
   assign stat.scan_fail  = eval && !hit && (dp_ff == PAGE_LAST) && (dr_ff == ROW_LAST);
   assign stat.mod_done   = (mcnt_ff == h_ff) && !mdv_ff;

   assign rsp_found       = rsp_found_ff;
   assign rsp_out_page    = rsp_page_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_range_error = rsp_range_error_ff;

`ifndef SYNTHESIS
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_en && mdv_ff))
      else $error("clearing sweep and rectangle write in the same cycle");

   a_scan_tag_in_range: assert property (@(posedge clock) disable iff (reset)
      eval |-> (EW'(dp_ff) < EW'(NUM_PAGES)))
      else $error("scan evaluated a row beyond the last page");

   a_hit_sets_found: assert property (@(posedge clock) disable iff (reset)
      hit && !req_load |=> res_found_ff)
      else $error("hit did not record a found result");
`endif

endmodule

// ----- rtl/core/rba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Rectangle block allocator controller
// Sequences clearing, scanning, rectangle marking and result hand-off.
// ----------------------------------------------------------------------------
module rba_ctrl import rba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  rba_stat_type stat,
   output rba_cmd_type  cmd,
   output logic         req_load
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_MOD,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_load  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_load) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_free) begin
               if (stat.range_bad || stat.free_noop) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.mod_start = 1'b1;
                  state_in      = ST_MOD;
               end
            end else if (stat.size_bad) begin
               state_in = ST_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.hit) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end else if (stat.scan_fail) begin
               state_in = ST_DONE;
            end
         end
         ST_MOD: begin
            cmd.mod_en = 1'b1;
            if (stat.mod_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/core/paged_rect_block_allocator.sv -----
// ----------------------------------------------------------------------------
// Paged rectangle block allocator
// First-fit allocator of rectangles in a bitmap of pages of cells.
// ----------------------------------------------------------------------------
// Usage
// An item on the req_ channel either allocates a rect_width x rect_height
// rectangle (op 0) or frees the rectangle at page_index / corner_x /
// corner_y (op 1). Every item yields exactly one item on the rsp_ channel.
// Allocation searches page by page, row by row, column by column and
// returns the first free position; found is low when nothing fits.
// A free whose rectangle crosses the page edge raises range_error and
// changes nothing.
// An allocation reads one row word per cycle while it searches, then
// reads each row of the found rectangle and writes it back marked. A
// free that changes cells reads and rewrites each row of its rectangle;
// a rejected or empty free changes no cells. Items are handled one at a
// time; the single memory read port sets the pace of the search.
// After reset the block sweeps the whole bitmap to zero, one row word a
// cycle, and holds req_ready low meanwhile.
// The result sits in an output register; while the receiver stalls the
// block may finish the next item, which then waits until the slot frees.
// ----------------------------------------------------------------------------
module paged_rect_block_allocator import rba_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   parameter int PAGE_COLS = PAGE_COLS_DEF,
   parameter int PAGE_ROWS = PAGE_ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_op,
   input  logic [5:0] req_rect_width,
   input  logic [5:0] req_rect_height,
   input  logic [3:0] req_page_index,
   input  logic [4:0] req_corner_x,
   input  logic [4:0] req_corner_y,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [3:0] rsp_out_page,
   output logic [4:0] rsp_out_x,
   output logic [4:0] rsp_out_y,
   output logic       rsp_range_error
);

   rba_cmd_type  cmd;
   rba_stat_type stat;
   logic         req_load;

   // The controller owns the handshakes and the sequence of phases.
   rba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_load  (req_load)
   );

   // The datapath holds the bitmap, the scan logic and the result register.
   rba_datapath #(
      .NUM_PAGES (NUM_PAGES),
      .PAGE_COLS (PAGE_COLS),
      .PAGE_ROWS (PAGE_ROWS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_load        (req_load),
      .req_op          (req_op),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_page_index  (req_page_index),
      .req_corner_x    (req_corner_x),
      .req_corner_y    (req_corner_y),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_found       (rsp_found),
      .rsp_out_page    (rsp_out_page),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_range_error (rsp_range_error)
   );

endmodule

// ----- sim/paged_rect_block_allocator_test.sv -----
// ----------------------------------------------------------------------------
// Paged rectangle block allocator testbench
// Drives allocate and free items with random idling on both channels. A
// shadow occupancy bitmap predicts every result, and each result is checked
// field by field in order.
// ----------------------------------------------------------------------------
module paged_rect_block_allocator_test;
   import rba_pkg::*;

   localparam int NPG = NUM_PAGES_DEF;
   localparam int NCOL = PAGE_COLS_DEF;
   localparam int NROW = PAGE_ROWS_DEF;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic       found;
      logic [3:0] page;
      logic [4:0] x;
      logic [4:0] y;
      logic       range_error;
   } alloc_result_t;

   // The scoreboard owns a shadow bitmap and the queue of pending results.
   class alloc_scoreboard;
      logic [NCOL-1:0] occ [NPG*NROW];
      alloc_result_t pending [$];
      int errors;

      function new();
         foreach (occ[i]) occ[i] = '0;
         errors = 0;
      endfunction

      function automatic logic [NCOL-1:0] span_mask(int w, int x);
         logic [NCOL-1:0] m;
         m = '0;
         for (int c = 0; c < w; c++) m[x + c] = 1'b1;
         return m;
      endfunction

      function automatic bit area_clear(int base, int y, int h, logic [NCOL-1:0] m);
         for (int r = 0; r < h; r++)
            if ((occ[base + y + r] & m) != '0) return 0;
         return 1;
      endfunction

      // Notes an accepted request and queues the result it must give.
      function void note_request(logic op, int w, int h, int pg, int cx, int cy);
         alloc_result_t res;
         logic [NCOL-1:0] m;
         bit done;
         res = '0;
         done = 0;
         if (op == OP_ALLOC) begin
            if (w >= 1 && h >= 1 && w <= NCOL && h <= NROW) begin
               for (int p = 0; p < NPG && !done; p++)
                  for (int y = 0; y + h <= NROW && !done; y++)
                     for (int x = 0; x + w <= NCOL && !done; x++) begin
                        m = span_mask(w, x);
                        if (area_clear(p * NROW, y, h, m)) begin
                           for (int r = 0; r < h; r++) occ[p * NROW + y + r] |= m;
                           res.found = 1'b1;
                           res.page = 4'(p);
                           res.x = 5'(x);
                           res.y = 5'(y);
                           done = 1;
                        end
                     end
            end
         end else if (pg >= NPG || cx + w > NCOL || cy + h > NROW) begin
            res.range_error = 1'b1;
         end else begin
            if (w != 0 && h != 0) begin
               m = span_mask(w, cx);
               for (int r = 0; r < h; r++) occ[pg * NROW + cy + r] &= ~m;
            end
            res.found = 1'b1;
         end
         pending.push_back(res);
      endfunction

      function void check_result(alloc_result_t act);
         alloc_result_t exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, act);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (exp.found !== act.found) begin
            $display("%0t: found expected %0d actual %0d", $time, exp.found, act.found);
            errors++;
         end
         if (exp.page !== act.page) begin
            $display("%0t: out_page expected %0d actual %0d", $time, exp.page, act.page);
            errors++;
         end
         if (exp.x !== act.x) begin
            $display("%0t: out_x expected %0d actual %0d", $time, exp.x, act.x);
            errors++;
         end
         if (exp.y !== act.y) begin
            $display("%0t: out_y expected %0d actual %0d", $time, exp.y, act.y);
            errors++;
         end
         if (exp.range_error !== act.range_error) begin
            $display("%0t: range_error expected %0d actual %0d", $time,
                     exp.range_error, act.range_error);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_op;
   logic [5:0] req_rect_width;
   logic [5:0] req_rect_height;
   logic [3:0] req_page_index;
   logic [4:0] req_corner_x;
   logic [4:0] req_corner_y;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_found;
   logic [3:0] rsp_out_page;
   logic [4:0] rsp_out_x;
   logic [4:0] rsp_out_y;
   logic       rsp_range_error;

   alloc_scoreboard board;
   longint cycle_count;
   // While this is set neither side idles, giving a long unbroken stretch.
   bit no_idle;

   // Rectangles handed out so far, kept so that frees can return real ones.
   typedef struct {
      int pg;
      int x;
      int y;
      int w;
      int h;
   } held_rect_t;
   held_rect_t held [$];

   paged_rect_block_allocator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_page_index(req_page_index), .req_corner_x(req_corner_x),
      .req_corner_y(req_corner_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_found(rsp_found),
      .rsp_out_page(rsp_out_page), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_range_error(rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
      no_idle = 0;
   end

   // Watchdog: the block sweeps its bitmap after reset and an allocation may
   // scan every row, so the limit is many times the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Results are sampled at the rising edge; ready changes at the falling one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_found, rsp_out_page, rsp_out_x, rsp_out_y,
                             rsp_range_error});
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= no_idle || ($urandom_range(99) >= 8);
   end

   // Presents one item and waits until it is accepted. The expectation is
   // recorded at the accepting edge so the shadow bitmap stays in step.
   // Valid is dropped only for idle cycles, so back-to-back items keep it
   // high across the hand-over.
   task automatic send_item(logic op, int w, int h, int pg, int cx, int cy);
      while (!no_idle && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_rect_width <= 6'(w);
      req_rect_height <= 6'(h);
      req_page_index <= 4'(pg);
      req_corner_x <= 5'(cx);
      req_corner_y <= 5'(cy);
      do @(posedge clock); while (!req_ready);
      board.note_request(op, w, h, pg, cx, cy);
      if (op == OP_ALLOC && board.pending[$].found)
         held.push_back('{int'(board.pending[$].page), int'(board.pending[$].x),
                          int'(board.pending[$].y), w, h});
      @(negedge clock);
   endtask

   task automatic alloc_item(int w, int h);
      send_item(OP_ALLOC, w, h, $urandom_range(15), $urandom_range(31),
                $urandom_range(31));
   endtask

   task automatic free_item(int pg, int cx, int cy, int w, int h);
      send_item(OP_FREE, w, h, pg, cx, cy);
   endtask

   // Returns one held rectangle, chosen at random.
   task automatic free_held();
      int k;
      held_rect_t r;
      k = $urandom_range(held.size() - 1);
      r = held[k];
      held.delete(k);
      free_item(r.pg, r.x, r.y, r.w, r.h);
   endtask

   // Mostly small rectangles so that pages fill and fragment quickly.
   function automatic int pick_size();
      int s;
      s = $urandom_range(99);
      if (s < 70) return $urandom_range(1, 6);
      if (s < 95) return $urandom_range(1, 16);
      return $urandom_range(0, 63);
   endfunction

   initial begin
      int sel;
      held_rect_t r;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_ALLOC;
      req_rect_width = '0;
      req_rect_height = '0;
      req_page_index = '0;
      req_corner_x = '0;
      req_corner_y = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes of the sizes, zero sizes, oversize requests and
      // frees that run past the page edge or name a freed area twice.
      alloc_item(1, 1);
      alloc_item(32, 32);
      alloc_item(0, 5);
      alloc_item(5, 0);
      alloc_item(33, 1);
      alloc_item(1, 63);
      alloc_item(63, 63);
      alloc_item(31, 1);
      alloc_item(2, 1);
      free_item(0, 0, 0, 1, 1);
      free_item(0, 0, 0, 1, 1);
      free_item(1, 0, 0, 32, 32);
      free_item(15, 31, 31, 1, 1);
      free_item(15, 31, 0, 2, 1);
      free_item(15, 0, 31, 1, 2);
      free_item(3, 0, 0, 0, 7);
      free_item(3, 5, 5, 7, 0);
      free_item(0, 31, 31, 63, 63);
      free_item(2, 16, 16, 16, 16);
      alloc_item(4, 4);
      alloc_item(32, 1);
      alloc_item(1, 32);

      // Random: mostly allocations and frees of held rectangles, with some
      // arbitrary frees as noise. A middle stretch runs without idling.
      for (int n = 0; n < 1100; n++) begin
         no_idle = (n >= 400 && n < 550);
         sel = $urandom_range(99);
         if (sel < 50)
            alloc_item(pick_size(), pick_size());
         else if (sel < 88 && held.size() > 0)
            free_held();
         else if (sel < 94 && held.size() > 0) begin
            // Part of a held rectangle; the rest stays in use.
            r = held[$urandom_range(held.size() - 1)];
            free_item(r.pg, r.x, r.y, $urandom_range(0, r.w), $urandom_range(0, r.h));
         end else
            free_item($urandom_range(15), $urandom_range(31), $urandom_range(31),
                      $urandom_range(0, 63), $urandom_range(0, 63));
      end
      no_idle = 0;
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
